// ----- src/csem_pkg.sv -----
// ----------------------------------------------------------------------------
// Counting semaphore package
// Shared constants, codes and the command and status types that pass between
// the controller and the datapath.
// ----------------------------------------------------------------------------
package csem_pkg;

  localparam int QUEUE_DEPTH  = 16;
  localparam int TASK_ID_BITS = 8;

  localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int OCC_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int COUNT_W = 16;
  localparam int INIT_W  = 15;
  localparam int ACT_W   = 2;
  localparam int TASK_W  = 8;
  localparam int STAT_W  = 3;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 16'h7FFF;

  localparam logic [ACT_W-1:0] ACT_DOWN    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_UP      = 2'd1;
  localparam logic [ACT_W-1:0] ACT_DESTROY = 2'd2;

  localparam logic [STAT_W-1:0] ST_GRANTED       = 3'd0;
  localparam logic [STAT_W-1:0] ST_BLOCKED       = 3'd1;
  localparam logic [STAT_W-1:0] ST_RELEASED      = 3'd2;
  localparam logic [STAT_W-1:0] ST_WOKE          = 3'd3;
  localparam logic [STAT_W-1:0] ST_DESTROY_WOKE  = 3'd4;
  localparam logic [STAT_W-1:0] ST_DESTROY_EMPTY = 3'd5;
  localparam logic [STAT_W-1:0] ST_OVERFLOW      = 3'd6;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_GRANT,
    OP_BLOCK,
    OP_OVERFLOW,
    OP_WAKE,
    OP_RELEASE_INC,
    OP_RELEASE,
    OP_DESTROY_EMPTY,
    OP_DRAIN
  } op_e;

  typedef struct packed {
    op_e op;
  } ctrl_cmd_t;

  typedef struct packed {
    logic count_pos;
    logic count_neg;
    logic count_max;
    logic queue_full;
    logic queue_empty;
    logic queue_one;
    logic out_free;
  } dp_status_t;

endpackage

// ----- src/csem_ctrl.sv -----
// ----------------------------------------------------------------------------
// Counting semaphore controller
// Decodes each accepted down or up word, and a destroy on an empty queue,
// into one datapath operation and sequences the wait queue drain on destroy.
// ----------------------------------------------------------------------------
module csem_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic [csem_pkg::ACT_W-1:0]   action_i,
  input  csem_pkg::dp_status_t         status_i,
  output logic                         in_ready_o,
  output csem_pkg::ctrl_cmd_t          cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_DRAIN = 2'b10
  } state_e;

  state_e state_q, state_d;
  csem_pkg::op_e op;

  assign in_ready_o = (state_q == S_IDLE) && status_i.out_free;

  always_comb begin
    state_d = state_q;
    op      = csem_pkg::OP_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          unique case (action_i)
            csem_pkg::ACT_DOWN: begin
              if (status_i.count_pos) begin
                op = csem_pkg::OP_GRANT;
              end else if (status_i.queue_full) begin
                op = csem_pkg::OP_OVERFLOW;
              end else begin
                op = csem_pkg::OP_BLOCK;
              end
            end
            csem_pkg::ACT_UP: begin
              if (status_i.count_max) begin
                op = csem_pkg::OP_OVERFLOW;
              end else if (status_i.count_neg && !status_i.queue_empty) begin
                op = csem_pkg::OP_WAKE;
              end else if (!status_i.count_neg) begin
                op = csem_pkg::OP_RELEASE_INC;
              end else begin
                op = csem_pkg::OP_RELEASE;
              end
            end
            csem_pkg::ACT_DESTROY: begin
              if (status_i.queue_empty) begin
                op = csem_pkg::OP_DESTROY_EMPTY;
              end else begin
                state_d = S_DRAIN;
              end
            end
            default: op = csem_pkg::OP_NONE;
          endcase
        end
      end
      S_DRAIN: begin
        if (status_i.out_free) begin
          op = csem_pkg::OP_DRAIN;
          if (status_i.queue_one) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign cmd_o.op = op;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- src/csem_dp.sv -----
// ----------------------------------------------------------------------------
// Counting semaphore datapath
// Holds the count, the wait queue memory with its pointers, the initial count
// register and the result register.
// ----------------------------------------------------------------------------
module csem_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [csem_pkg::INIT_W-1:0]   cfg_wdata_i,
  input  logic [csem_pkg::TASK_W-1:0]   task_id_i,
  input  csem_pkg::ctrl_cmd_t           cmd_i,
  input  logic                          out_ready_i,
  output csem_pkg::dp_status_t          status_o,
  output logic                          out_valid_o,
  output logic [csem_pkg::STAT_W-1:0]   out_status_o,
  output logic [csem_pkg::TASK_W-1:0]   out_woken_o,
  output logic                          out_last_o
);

  localparam int Depth  = csem_pkg::QUEUE_DEPTH;
  localparam int PtrW   = csem_pkg::PTR_W;
  localparam int OccW   = csem_pkg::OCC_W;
  localparam int CountW = csem_pkg::COUNT_W;
  localparam int IdW    = csem_pkg::TASK_ID_BITS;
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [OccW-1:0] OccFull = OccW'(Depth);
  localparam logic [OccW-1:0] OccOne  = OccW'(1);

  logic [csem_pkg::INIT_W-1:0] init_q;
  logic [CountW-1:0]           count_q, count_d;
  logic [PtrW-1:0]             head_q, head_d, tail_q, tail_d;
  logic [OccW-1:0]             occ_q, occ_d;
  logic [IdW-1:0]              fifo_mem [Depth];
  logic [IdW-1:0]              rd_q;
  logic [IdW-1:0]              push_id;
  logic                        push, pop, reload, emit;
  logic                        out_valid_q;
  logic [csem_pkg::STAT_W-1:0] out_status_q, out_status_d;
  logic [csem_pkg::TASK_W-1:0] out_woken_q, out_woken_d;
  logic                        out_last_q, out_last_d;

  assign push_id = task_id_i[IdW-1:0];

  assign status_o.count_pos   = !count_q[CountW-1] && (count_q != '0);
  assign status_o.count_neg   = count_q[CountW-1];
  assign status_o.count_max   = (count_q == csem_pkg::COUNT_MAX);
  assign status_o.queue_full  = (occ_q >= OccFull);
  assign status_o.queue_empty = (occ_q == '0);
  assign status_o.queue_one   = (occ_q == OccOne);
  assign status_o.out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    count_d      = count_q;
    push         = 1'b0;
    pop          = 1'b0;
    reload       = 1'b0;
    emit         = 1'b1;
    out_status_d = csem_pkg::ST_RELEASED;
    out_woken_d  = '0;
    out_last_d   = 1'b1;
    unique case (cmd_i.op)
      csem_pkg::OP_GRANT: begin
        count_d      = count_q - CountW'(1);
        out_status_d = csem_pkg::ST_GRANTED;
      end
      csem_pkg::OP_BLOCK: begin
        count_d      = count_q - CountW'(1);
        push         = 1'b1;
        out_status_d = csem_pkg::ST_BLOCKED;
      end
      csem_pkg::OP_OVERFLOW: out_status_d = csem_pkg::ST_OVERFLOW;
      csem_pkg::OP_WAKE: begin
        count_d      = count_q + CountW'(1);
        pop          = 1'b1;
        out_status_d = csem_pkg::ST_WOKE;
        out_woken_d  = csem_pkg::TASK_W'(rd_q);
      end
      csem_pkg::OP_RELEASE_INC: begin
        count_d      = count_q + CountW'(1);
        out_status_d = csem_pkg::ST_RELEASED;
      end
      csem_pkg::OP_RELEASE: out_status_d = csem_pkg::ST_RELEASED;
      csem_pkg::OP_DESTROY_EMPTY: begin
        reload       = 1'b1;
        out_status_d = csem_pkg::ST_DESTROY_EMPTY;
      end
      csem_pkg::OP_DRAIN: begin
        pop          = 1'b1;
        reload       = (occ_q == OccOne);
        out_status_d = csem_pkg::ST_DESTROY_WOKE;
        out_woken_d  = csem_pkg::TASK_W'(rd_q);
        out_last_d   = (occ_q == OccOne);
      end
      default: emit = 1'b0;
    endcase
    if (reload) begin
      count_d = CountW'(init_q);
    end
  end

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    occ_d  = occ_q;
    if (push) begin
      tail_d = (tail_q == PtrLast) ? '0 : tail_q + PtrW'(1);
      occ_d  = occ_q + OccW'(1);
    end
    if (pop) begin
      head_d = (head_q == PtrLast) ? '0 : head_q + PtrW'(1);
      occ_d  = occ_q - OccW'(1);
    end
    if (reload) begin
      head_d  = '0;
      tail_d  = '0;
      occ_d   = '0;
    end
  end

  // The read port follows the next head, so the oldest waiter is always ready.
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_mem[tail_q] <= push_id;
    end
    if (push && (tail_q == head_d)) begin
      rd_q <= push_id;
    end else begin
      rd_q <= fifo_mem[head_d];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q      <= '0;
      count_q     <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        init_q <= cfg_wdata_i;
      end
      count_q     <= count_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      occ_q       <= occ_d;
      out_valid_q <= emit || (out_valid_q && !out_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_status_q <= out_status_d;
      out_woken_q  <= out_woken_d;
      out_last_q   <= out_last_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_woken_o  = out_woken_q;
  assign out_last_o   = out_last_q;

endmodule

// ----- src/counting_semaphore_wait_queue.sv -----
// ----------------------------------------------------------------------------
// Counting semaphore with wait queue
// Top level joining the controller and the datapath to the stream ports.
// ----------------------------------------------------------------------------
// A down or an up word yields one result word, and so does a destroy on an
// empty queue. Otherwise a destroy yields one result word per queued waiter,
// because the drain reads one waiter from the wait queue memory each cycle
// while the output register is free. Results leave through an output
// register, and a new word is taken only when that register is empty or its
// result leaves in the same cycle, so a stalled output holds off new words.
// The initial count written on the configuration port is used at the next
// destroy.
module counting_semaphore_wait_queue (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [14:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // action [1:0], task_id [9:2], zeros above.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // status [2:0], woken_task [10:3], zeros above.
  output logic        m_axis_tlast
);

  csem_pkg::ctrl_cmd_t          cmd;
  csem_pkg::dp_status_t         status;
  logic [csem_pkg::STAT_W-1:0]  out_status;
  logic [csem_pkg::TASK_W-1:0]  out_woken;

  csem_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .action_i   (s_axis_tdata[1:0]),
    .status_i   (status),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd)
  );

  csem_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .task_id_i    (s_axis_tdata[9:2]),
    .cmd_i        (cmd),
    .out_ready_i  (m_axis_tready),
    .status_o     (status),
    .out_valid_o  (m_axis_tvalid),
    .out_status_o (out_status),
    .out_woken_o  (out_woken),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {5'b0, out_woken, out_status};

endmodule

// ----- tb/sv/csem_result_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Counting semaphore result checker
// Watches the configuration port and both stream channels, keeps its own
// model of the count and the wait queue, and compares every result word
// against the oldest prediction.
// ----------------------------------------------------------------------------
module csem_result_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [14:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // action [1:0], task_id [9:2], zeros above.
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,  // status [2:0], woken_task [10:3], zeros above.
  input  logic        m_axis_tlast,
  output int          pending_o,
  output int          checked_o,
  output int          fail_count_o
);

  typedef struct packed {
    logic [csem_pkg::STAT_W-1:0] status;
    logic [csem_pkg::TASK_W-1:0] woken;
    logic                        last;
  } result_t;

  logic        [csem_pkg::INIT_W-1:0]  init_count;
  logic signed [csem_pkg::COUNT_W-1:0] level;
  logic        [csem_pkg::TASK_W-1:0]  waiters [csem_pkg::QUEUE_DEPTH];
  logic        [csem_pkg::PTR_W-1:0]   rd_ptr;
  logic        [csem_pkg::PTR_W-1:0]   wr_ptr;
  logic        [csem_pkg::OCC_W-1:0]   n_waiting;
  result_t                             owed_results [$];

  task automatic report_mismatch(input string msg);
    $display("tb: mismatch: %s", msg);
    fail_count_o++;
  endtask

  function automatic void owe(input logic [csem_pkg::STAT_W-1:0] status,
                              input logic [csem_pkg::TASK_W-1:0] woken, input logic last);
    result_t r;
    r.status = status;
    r.woken  = woken;
    r.last   = last;
    owed_results.push_back(r);
  endfunction

  function automatic logic [csem_pkg::TASK_W-1:0] take_oldest();
    logic [csem_pkg::TASK_W-1:0] id;
    id = waiters[rd_ptr];
    rd_ptr++;
    n_waiting--;
    return id;
  endfunction

  task automatic apply_action(input logic [csem_pkg::ACT_W-1:0] act,
                              input logic [csem_pkg::TASK_W-1:0] id);
    logic [csem_pkg::TASK_W-1:0] t;
    case (act)
      csem_pkg::ACT_DOWN: begin
        if (level > 0) begin
          level--;
          owe(csem_pkg::ST_GRANTED, '0, 1'b1);
        end else if (n_waiting == csem_pkg::QUEUE_DEPTH) begin
          owe(csem_pkg::ST_OVERFLOW, '0, 1'b1);
        end else begin
          level--;
          waiters[wr_ptr] = id;
          wr_ptr++;
          n_waiting++;
          owe(csem_pkg::ST_BLOCKED, '0, 1'b1);
        end
      end
      csem_pkg::ACT_UP: begin
        if (level == $signed(csem_pkg::COUNT_MAX)) begin
          owe(csem_pkg::ST_OVERFLOW, '0, 1'b1);
        end else if (level < 0 && n_waiting != 0) begin
          level++;
          owe(csem_pkg::ST_WOKE, take_oldest(), 1'b1);
        end else begin
          if (level >= 0) level++;
          owe(csem_pkg::ST_RELEASED, '0, 1'b1);
        end
      end
      csem_pkg::ACT_DESTROY: begin
        if (n_waiting == 0) begin
          owe(csem_pkg::ST_DESTROY_EMPTY, '0, 1'b1);
        end else begin
          while (n_waiting != 0) begin
            t = take_oldest();
            owe(csem_pkg::ST_DESTROY_WOKE, t, n_waiting == 0);
          end
        end
        level     = {1'b0, init_count};
        rd_ptr    = '0;
        wr_ptr    = '0;
        n_waiting = '0;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      init_count   = '0;
      level        = '0;
      rd_ptr       = '0;
      wr_ptr       = '0;
      n_waiting    = '0;
      checked_o    = 0;
      fail_count_o = 0;
      owed_results.delete();
      pending_o <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (owed_results.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with none expected (status %0d)",
                                    checked_o, m_axis_tdata[2:0]));
        end else begin
          want = owed_results.pop_front();
          if (m_axis_tdata[2:0] != want.status)
            report_mismatch($sformatf("result %0d status is %0d, expected %0d",
                                      checked_o, m_axis_tdata[2:0], want.status));
          if (m_axis_tdata[10:3] != want.woken)
            report_mismatch($sformatf("result %0d woken task is %0d, expected %0d",
                                      checked_o, m_axis_tdata[10:3], want.woken));
          if (m_axis_tlast !== want.last)
            report_mismatch($sformatf("result %0d last is %b, expected %b",
                                      checked_o, m_axis_tlast, want.last));
        end
        checked_o++;
      end
      if (s_axis_tvalid && s_axis_tready) apply_action(s_axis_tdata[1:0], s_axis_tdata[9:2]);
      if (cfg_we_i) init_count = cfg_wdata_i;
      pending_o <= owed_results.size();
    end
  end

endmodule

// ----- tb/sv/counting_semaphore_wait_queue_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Counting semaphore with wait queue testbench
// Drives a directed sequence covering grants, blocking, wakes, destroys and
// both overflow cases, then random traffic under several initial counts and
// idle patterns, with a separate checker predicting every result word.
// ----------------------------------------------------------------------------
module counting_semaphore_wait_queue_test;

  localparam logic [csem_pkg::ACT_W-1:0] ACT_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int WORDS_PER_BLOCK = 33;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [14:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;  // action [1:0], task_id [9:2], zeros above.
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;  // status [2:0], woken_task [10:3], zeros above.
  logic        m_axis_tlast;

  int pending;
  int checked;
  int fail_count;
  int send_idle_pct = 15;
  int recv_idle_pct = 82;
  int idle_cycles = 0;
  int n_loads = 0;
  int n_down = 0;
  int n_up = 0;
  int n_destroy = 0;
  int n_unused = 0;

  always #5 clk_i = ~clk_i;

  counting_semaphore_wait_queue dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  csem_result_checker u_result_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .pending_o     (pending),
    .checked_o     (checked),
    .fail_count_o  (fail_count)
  );

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: watchdog expired with %0d results outstanding", pending);
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_word(input logic [csem_pkg::ACT_W-1:0] act,
                           input logic [csem_pkg::TASK_W-1:0] id);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, id, act};
    do @(posedge clk_i); while (!s_axis_tready);
    case (act)
      csem_pkg::ACT_DOWN:    n_down++;
      csem_pkg::ACT_UP:      n_up++;
      csem_pkg::ACT_DESTROY: n_destroy++;
      default:               n_unused++;
    endcase
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic load_initial_count(input logic [csem_pkg::INIT_W-1:0] value);
    wait_drained();
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    n_loads++;
  endtask

  initial begin
    int blk;
    int words;
    int pick;
    logic [csem_pkg::ACT_W-1:0] act;
    logic [csem_pkg::INIT_W-1:0] value;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_word(csem_pkg::ACT_UP, 8'h00);
    send_word(csem_pkg::ACT_DOWN, 8'h00);
    send_word(csem_pkg::ACT_DOWN, 8'hFF);
    send_word(csem_pkg::ACT_DOWN, 8'hA5);
    send_word(csem_pkg::ACT_UP, 8'h3C);
    send_word(ACT_UNUSED, 8'hFF);
    send_word(csem_pkg::ACT_DESTROY, 8'h00);
    send_word(csem_pkg::ACT_DESTROY, 8'hFF);
    repeat (csem_pkg::QUEUE_DEPTH) send_word(csem_pkg::ACT_DOWN, 8'($urandom_range(255)));
    send_word(csem_pkg::ACT_DOWN, 8'h5A);
    send_word(csem_pkg::ACT_DESTROY, 8'h00);

    load_initial_count(15'h7FFF);
    send_word(csem_pkg::ACT_DESTROY, 8'h00);
    send_word(csem_pkg::ACT_UP, 8'h00);
    send_word(csem_pkg::ACT_DOWN, 8'h81);
    send_word(csem_pkg::ACT_UP, 8'h00);
    send_word(csem_pkg::ACT_UP, 8'h00);

    for (blk = 0; blk < 9; blk++) begin
      if (blk == 3) begin
        send_idle_pct = 82;
        recv_idle_pct <= 15;
      end else if (blk == 6) begin
        send_idle_pct = 0;
        recv_idle_pct <= 0;
      end
      case (blk % 3)
        0:       value = 15'($urandom_range(3));
        1:       value = (blk == 4) ? 15'h7FFF : 15'h0000;
        default: value = (blk == 8) ? 15'($urandom_range(32767)) : 15'($urandom_range(5));
      endcase
      load_initial_count(value);
      send_word(csem_pkg::ACT_DESTROY, 8'($urandom_range(255)));
      words = 0;
      while (words < WORDS_PER_BLOCK) begin
        pick = $urandom_range(99);
        act = (pick < 45) ? csem_pkg::ACT_DOWN :
              (pick < 84) ? csem_pkg::ACT_UP :
              (pick < 93) ? csem_pkg::ACT_DESTROY : ACT_UNUSED;
        send_word(act, 8'($urandom_range(255)));
        if (act != ACT_UNUSED) words++;
      end
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    $display("tb: %0d downs, %0d ups, %0d destroys and %0d unused words",
             n_down, n_up, n_destroy, n_unused);
    $display("tb: %0d initial counts loaded, %0d result words compared, %0d mismatches",
             n_loads, checked, fail_count);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
